### rtl/serial_command_stepper_pulser_macros.svh
// assertion macros for the serial command stepper pulser
// expects clk and rst_n in the scope of the user
`ifndef SERIAL_COMMAND_STEPPER_PULSER_MACROS_SVH
`define SERIAL_COMMAND_STEPPER_PULSER_MACROS_SVH

`ifndef SYNTHESIS
`define SCSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsp assertion failed");
`define SCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsp assertion failed");
`else
`define SCSP_ASSERT_NOW(label, ante, cons)
`define SCSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/scsp_pkg.sv
// shared types and character codes for the serial command stepper pulser
// no dependencies
`timescale 1ns / 1ps

package scsp_pkg;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_0      = 8'd48;
  localparam logic [7:0] CH_9      = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_D      = 8'd68;
  localparam logic [7:0] CH_E      = 8'd69;
  localparam logic [7:0] CH_P      = 8'd80;
  localparam logic [7:0] CH_R      = 8'd82;
  localparam logic [7:0] CH_V      = 8'd86;
  localparam logic [7:0] CH_LA     = 8'd97;
  localparam logic [7:0] CH_LZ     = 8'd122;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  letter;
    logic [15:0] value;
  } cmd_t;

endpackage

### rtl/scsp_if.sv
// handshake channels of the serial command stepper pulser
// no dependencies
`timescale 1ns / 1ps

interface scsp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface scsp_out_if;
  logic valid;
  logic ready;
  logic step_out;
  logic direction_out;
  logic gripper_out;
  logic done_toggle;
  logic busy_res;
  logic time_error;

  modport source (output valid, output step_out, output direction_out, output gripper_out,
                  output done_toggle, output busy_res, output time_error, input ready);
  modport sink (input valid, input step_out, input direction_out, input gripper_out,
                input done_toggle, input busy_res, input time_error, output ready);
endinterface

### rtl/scsp_parser.sv
// frame and decimal number parser, emits one command when a frame closes
// depends on scsp_pkg
`timescale 1ns / 1ps

module scsp_parser #(
  parameter int COMMAND_LENGTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_en,
  input  logic [7:0]       data_byte,
  output scsp_pkg::cmd_t   cmd
);
  import scsp_pkg::*;

  localparam int CW = $clog2(COMMAND_LENGTH + 1);

  logic          frame_open_r, frame_open_nxt;
  logic [CW-1:0] char_count_r, char_count_nxt;
  logic [7:0]    letter_r, letter_nxt;
  phase_t        phase_r, phase_nxt;
  logic          negative_r, negative_nxt;
  logic [15:0]   value_r, value_nxt;

  always_comb begin
    logic take;
    logic digit;
    logic space;
    take           = 1'b1;
    digit          = (data_byte >= CH_0) && (data_byte <= CH_9);
    space          = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_FF));
    frame_open_nxt = frame_open_r;
    char_count_nxt = char_count_r;
    letter_nxt     = letter_r;
    phase_nxt      = phase_r;
    negative_nxt   = negative_r;
    value_nxt      = value_r;
    cmd            = '0;
    if (byte_en && data_byte != CH_NUL) begin
      priority if (data_byte == CH_COLON) begin
        frame_open_nxt = 1'b1;
        char_count_nxt = '0;
        letter_nxt     = '0;
        phase_nxt      = PH_SKIP;
        negative_nxt   = 1'b0;
        value_nxt      = '0;
      end else if (data_byte == CH_CR) begin
        if (frame_open_r) begin
          frame_open_nxt = 1'b0;
          cmd.valid      = 1'b1;
          cmd.letter     = ((letter_r >= CH_LA) && (letter_r <= CH_LZ)) ?
                           (letter_r - CASE_DIFF) : letter_r;
          cmd.value      = negative_r ? (16'd0 - value_r) : value_r;
        end
      end else if (frame_open_r && char_count_r < CW'(COMMAND_LENGTH)) begin
        char_count_nxt = char_count_r + CW'(1);
        if (char_count_r == '0) begin
          letter_nxt = data_byte;
        end else begin
          if (phase_r == PH_SKIP) begin
            if (space) begin
              take = 1'b0;
            end else if (data_byte == CH_PLUS) begin
              phase_nxt = PH_SIGN;
              take      = 1'b0;
            end else if (data_byte == CH_MINUS) begin
              phase_nxt    = PH_SIGN;
              negative_nxt = 1'b1;
              take         = 1'b0;
            end
          end
          if (take && phase_r != PH_DONE) begin
            if (digit) begin
              value_nxt = (value_r << 3) + (value_r << 1) + 16'(data_byte - CH_0);
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end else begin
        // closed frame or full command buffer: byte is dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      char_count_r <= '0;
      letter_r     <= '0;
      phase_r      <= PH_SKIP;
      negative_r   <= 1'b0;
      value_r      <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      char_count_r <= char_count_nxt;
      letter_r     <= letter_nxt;
      phase_r      <= phase_nxt;
      negative_r   <= negative_nxt;
      value_r      <= value_nxt;
    end
  end

endmodule

### rtl/serial_command_stepper_pulser.sv
// serial command stepper pulser: one result item per input item, held in a result register
// accepts one item per cycle unless a result is stalled; the result register lets a new item in while the
// previous result is being taken in the same cycle
// a stalled result holds the input back until it is taken
// synchronous active-low reset restores the default settings and clears the run
// depends on scsp_pkg, scsp_if, scsp_parser and the macros header
`timescale 1ns / 1ps
`include "serial_command_stepper_pulser_macros.svh"

module serial_command_stepper_pulser #(
  parameter int COMMAND_LENGTH  = 16,
  parameter int MAX_HALF_PERIOD = 4194
) (
  input logic        clk,
  input logic        rst_n,
  scsp_in_if.sink    in_ch,
  scsp_out_if.source out_ch
);
  import scsp_pkg::*;

  localparam int          TW    = $clog2(MAX_HALF_PERIOD + 1);
  localparam logic [15:0] MAX_H = 16'(MAX_HALF_PERIOD);

  logic        in_acc;
  cmd_t        cmd;

  logic [15:0]   steps_r, steps_nxt;
  logic          dir_set_r, dir_set_nxt;
  logic [15:0]   half_set_r, half_set_nxt;
  logic          gripper_r, gripper_nxt;
  logic          done_r, done_nxt;
  logic          running_r, running_nxt;
  logic          step_r, step_nxt;
  logic [TW-1:0] tick_count_r, tick_count_nxt;
  logic [15:0]   pulses_r, pulses_nxt;
  logic          clamp_r, clamp_nxt;
  logic [14:0]   run_target_r, run_target_nxt;
  logic [TW-1:0] run_half_r, run_half_nxt;
  logic          run_dir_r, run_dir_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_step_r, out_dir_r, out_grip_r, out_done_r, out_busy_r, out_err_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  scsp_parser #(
    .COMMAND_LENGTH(COMMAND_LENGTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_acc && in_ch.operation == OP_BYTE),
    .data_byte (in_ch.data_byte),
    .cmd       (cmd)
  );

  always_comb begin
    logic [TW-1:0] t;
    logic [15:0]   p;
    t              = tick_count_r + TW'(1);
    p              = pulses_r + 16'd1;
    steps_nxt      = steps_r;
    dir_set_nxt    = dir_set_r;
    half_set_nxt   = half_set_r;
    gripper_nxt    = gripper_r;
    done_nxt       = done_r;
    running_nxt    = running_r;
    step_nxt       = step_r;
    tick_count_nxt = tick_count_r;
    pulses_nxt     = pulses_r;
    clamp_nxt      = clamp_r;
    run_target_nxt = run_target_r;
    run_half_nxt   = run_half_r;
    run_dir_nxt    = run_dir_r;
    if (in_acc && in_ch.operation == OP_TICK && running_r) begin
      if (t < run_half_r) begin
        tick_count_nxt = t;
      end else begin
        tick_count_nxt = '0;
        step_nxt       = !step_r;
        if (step_r) begin
          pulses_nxt = p;
          if (p >= {1'b0, run_target_r}) begin
            running_nxt = 1'b0;
            done_nxt    = !done_r;
          end
        end
      end
    end else if (cmd.valid) begin
      unique case (cmd.letter)
        CH_P: begin
          steps_nxt = cmd.value;
          done_nxt  = !done_r;
        end
        CH_D: begin
          dir_set_nxt = (cmd.value != '0);
          done_nxt    = !done_r;
        end
        CH_V: begin
          half_set_nxt = cmd.value;
          done_nxt     = !done_r;
        end
        CH_E: begin
          gripper_nxt = (cmd.value != '0);
          done_nxt    = !done_r;
        end
        CH_R: begin
          clamp_nxt = 1'b0;
          if (half_set_r[15] || half_set_r == '0) begin
            run_half_nxt = TW'(1);
          end else if (half_set_r > MAX_H) begin
            run_half_nxt = TW'(MAX_HALF_PERIOD);
            clamp_nxt    = 1'b1;
          end else begin
            run_half_nxt = half_set_r[TW-1:0];
          end
          run_dir_nxt    = dir_set_r;
          tick_count_nxt = '0;
          pulses_nxt     = '0;
          if (steps_r[15] || steps_r == '0) begin
            running_nxt = 1'b0;
          end else begin
            run_target_nxt = steps_r[14:0];
            running_nxt    = 1'b1;
            done_nxt       = !done_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r      <= 16'd10;
      dir_set_r    <= 1'b0;
      half_set_r   <= 16'd100;
      gripper_r    <= 1'b0;
      done_r       <= 1'b0;
      running_r    <= 1'b0;
      step_r       <= 1'b0;
      tick_count_r <= '0;
      pulses_r     <= '0;
      clamp_r      <= 1'b0;
      run_target_r <= '0;
      run_half_r   <= TW'(1);
      run_dir_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      steps_r      <= steps_nxt;
      dir_set_r    <= dir_set_nxt;
      half_set_r   <= half_set_nxt;
      gripper_r    <= gripper_nxt;
      done_r       <= done_nxt;
      running_r    <= running_nxt;
      step_r       <= step_nxt;
      tick_count_r <= tick_count_nxt;
      pulses_r     <= pulses_nxt;
      clamp_r      <= clamp_nxt;
      run_target_r <= run_target_nxt;
      run_half_r   <= run_half_nxt;
      run_dir_r    <= run_dir_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_step_r <= step_nxt;
      out_dir_r  <= running_nxt && run_dir_nxt;
      out_grip_r <= gripper_nxt;
      out_done_r <= done_nxt;
      out_busy_r <= running_nxt;
      out_err_r  <= clamp_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_out      = out_step_r;
  assign out_ch.direction_out = out_dir_r;
  assign out_ch.gripper_out   = out_grip_r;
  assign out_ch.done_toggle   = out_done_r;
  assign out_ch.busy_res      = out_busy_r;
  assign out_ch.time_error    = out_err_r;

  `SCSP_ASSERT_NOW(a_ready_when_empty, !in_ch.ready, out_valid_r)
  `SCSP_ASSERT_NOW(a_dir_only_busy, out_valid_r && out_dir_r, out_busy_r)
  `SCSP_ASSERT_NOW(a_tick_in_range, running_r, run_half_r != '0 && tick_count_r < run_half_r)
  `SCSP_ASSERT_NEXT(a_idle_tick_keeps_done, in_acc && in_ch.operation == OP_TICK && !running_r,
                    done_r == $past(done_r) && !running_r)

endmodule

### bench/tb_top.sv
// testbench for serial_command_stepper_pulser: a directed table, then random frames and ticks
// every result item is checked against a model of the parser and step run, or its table row
// depends on scsp_pkg, scsp_if and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import scsp_pkg::*;

  localparam int CMD_LEN  = 16;
  localparam int HALF_MAX = 4194;

  typedef struct packed {
    logic step;
    logic dir;
    logic grip;
    logic done;
    logic busy;
    logic terr;
  } levels_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       known;
    levels_t    want;
  } stim_t;

  localparam logic [7:0] CMD_LETTERS [5] = '{CH_P, CH_D, CH_V, CH_E, CH_R};

  // want bits: step dir grip done busy terr
  localparam stim_t DIRECTED_ROWS [27] = '{
    '{OP_TICK, 8'hFF, 1'b1, 6'b000000},
    '{OP_BYTE, CH_NUL, 1'b1, 6'b000000},
    '{OP_BYTE, CH_E, 1'b1, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b000000},
    '{OP_BYTE, CH_COLON, 1'b0, 6'b000000},
    '{OP_BYTE, CH_E + CASE_DIFF, 1'b0, 6'b000000},
    '{OP_BYTE, CH_0 + 8'd7, 1'b0, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b001100},
    '{OP_BYTE, CH_COLON, 1'b0, 6'b000000},
    '{OP_BYTE, CH_V, 1'b0, 6'b000000},
    '{OP_BYTE, CH_0 + 8'd5, 1'b0, 6'b000000},
    '{OP_BYTE, CH_0, 1'b0, 6'b000000},
    '{OP_BYTE, CH_0, 1'b0, 6'b000000},
    '{OP_BYTE, CH_0, 1'b0, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b001000},
    '{OP_BYTE, CH_COLON, 1'b0, 6'b000000},
    '{OP_BYTE, CH_R + CASE_DIFF, 1'b0, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b001111},
    '{OP_BYTE, CH_COLON, 1'b0, 6'b000000},
    '{OP_BYTE, CH_V, 1'b0, 6'b000000},
    '{OP_BYTE, 8'hFF, 1'b0, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b001011},
    '{OP_BYTE, CH_COLON, 1'b0, 6'b000000},
    '{OP_BYTE, CH_R, 1'b0, 6'b000000},
    '{OP_BYTE, CH_CR, 1'b1, 6'b001110},
    '{OP_TICK, 8'h00, 1'b1, 6'b101110},
    '{OP_TICK, 8'h5A, 1'b1, 6'b001110}
  };

  logic clk = 1'b0;
  logic rst_n;

  scsp_in_if  in_ch ();
  scsp_out_if out_ch ();

  serial_command_stepper_pulser #(
    .COMMAND_LENGTH (CMD_LEN),
    .MAX_HALF_PERIOD(HALF_MAX)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // model state
  bit          frm_open;
  int unsigned chars_seen;
  logic [7:0]  cmd_letter;
  phase_t      num_phase;
  bit          num_neg;
  logic [15:0] num_acc;
  logic [15:0] steps_cfg;
  logic [15:0] half_cfg;
  bit          dir_cfg;
  bit          grip_lvl;
  bit          done_lvl;
  bit          run_on;
  bit          step_lvl;
  bit          clamp_seen;
  bit          run_dir_lvl;
  int unsigned tick_cnt;
  int unsigned half_len;
  logic [15:0] pulse_cnt;
  logic [15:0] pulse_goal;

  stim_t       stim_q[$];
  levels_t     expected_levels[$];
  int          planned_items = 0;
  int          taken_items = 0;
  int          error_count = 0;
  logic [7:0]  ready_cycle = 8'd0;

  function automatic void reset_model();
    frm_open = 1'b0;
    chars_seen = 0;
    cmd_letter = 8'd0;
    num_phase = PH_SKIP;
    num_neg = 1'b0;
    num_acc = 16'd0;
    steps_cfg = 16'd10;
    dir_cfg = 1'b0;
    half_cfg = 16'd100;
    grip_lvl = 1'b0;
    done_lvl = 1'b0;
    run_on = 1'b0;
    step_lvl = 1'b0;
    tick_cnt = 0;
    pulse_cnt = 16'd0;
    clamp_seen = 1'b0;
    pulse_goal = 16'd0;
    half_len = 1;
    run_dir_lvl = 1'b0;
  endfunction

  function automatic void number_char(logic [7:0] c);
    bit is_digit;
    is_digit = (c >= CH_0 && c <= CH_9);
    if (num_phase == PH_SKIP) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_FF)) return;
      if (c == CH_PLUS) begin
        num_phase = PH_SIGN;
        return;
      end
      if (c == CH_MINUS) begin
        num_neg = 1'b1;
        num_phase = PH_SIGN;
        return;
      end
    end
    if (num_phase == PH_DONE) return;
    if (is_digit) begin
      num_acc = num_acc * 16'd10 + {8'd0, c - CH_0};
      num_phase = PH_DIGITS;
    end else begin
      num_phase = PH_DONE;
    end
  endfunction

  function automatic void begin_run();
    int h;
    int s;
    h = $signed(half_cfg);
    s = $signed(steps_cfg);
    clamp_seen = 1'b0;
    if (h < 1) begin
      h = 1;
    end else if (h > HALF_MAX) begin
      h = HALF_MAX;
      clamp_seen = 1'b1;
    end
    half_len = h;
    run_dir_lvl = dir_cfg;
    tick_cnt = 0;
    pulse_cnt = 16'd0;
    if (s <= 0) begin
      run_on = 1'b0;
      done_lvl ^= 1'b1;
    end else begin
      pulse_goal = s[15:0];
      run_on = 1'b1;
    end
  endfunction

  function automatic void finish_frame();
    logic [15:0] v;
    logic [7:0]  ltr;
    v = num_neg ? -num_acc : num_acc;
    ltr = cmd_letter;
    if (ltr >= CH_LA && ltr <= CH_LZ) ltr = ltr - CASE_DIFF;
    case (ltr)
      CH_P: begin
        steps_cfg = v;
        done_lvl ^= 1'b1;
      end
      CH_D: begin
        dir_cfg = (v != 16'd0);
        done_lvl ^= 1'b1;
      end
      CH_V: begin
        half_cfg = v;
        done_lvl ^= 1'b1;
      end
      CH_E: begin
        grip_lvl = (v != 16'd0);
        done_lvl ^= 1'b1;
      end
      CH_R: begin
        done_lvl ^= 1'b1;
        begin_run();
      end
      default: ;
    endcase
  endfunction

  function automatic void link_byte(logic [7:0] b);
    if (b == CH_NUL) return;
    if (b == CH_COLON) begin
      frm_open = 1'b1;
      chars_seen = 0;
      cmd_letter = 8'd0;
      num_phase = PH_SKIP;
      num_neg = 1'b0;
      num_acc = 16'd0;
      return;
    end
    if (b == CH_CR) begin
      if (frm_open) begin
        frm_open = 1'b0;
        finish_frame();
      end
      return;
    end
    if (!frm_open || chars_seen >= CMD_LEN) return;
    if (chars_seen == 0) cmd_letter = b;
    else number_char(b);
    chars_seen++;
  endfunction

  function automatic void ms_tick();
    if (!run_on) return;
    if (tick_cnt + 1 < half_len) begin
      tick_cnt++;
      return;
    end
    tick_cnt = 0;
    step_lvl ^= 1'b1;
    if (!step_lvl) begin
      pulse_cnt = pulse_cnt + 16'd1;
      if (pulse_cnt >= pulse_goal) begin
        run_on = 1'b0;
        done_lvl ^= 1'b1;
      end
    end
  endfunction

  function automatic levels_t advance_model(logic op, logic [7:0] b);
    levels_t r;
    if (op == OP_TICK) ms_tick();
    else link_byte(b);
    r.step = step_lvl;
    r.dir  = run_on ? run_dir_lvl : 1'b0;
    r.grip = grip_lvl;
    r.done = done_lvl;
    r.busy = run_on;
    r.terr = clamp_seen;
    return r;
  endfunction

  // stimulus generation

  function automatic void push_stim(logic op, logic [7:0] d, bit counted);
    stim_t s;
    s.op = op;
    s.data = d;
    s.known = 1'b0;
    s.want = '0;
    stim_q.push_back(s);
    if (counted) planned_items++;
  endfunction

  function automatic void push_tick();
    push_stim(OP_TICK, 8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void frame_byte(logic [7:0] b);
    if ($urandom_range(0, 19) == 0) push_stim(OP_BYTE, CH_NUL, 1'b1);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_tick();
    push_stim(OP_BYTE, b, 1'b1);
  endfunction

  function automatic void add_frame();
    logic [7:0]  ltr;
    int unsigned pick;
    int unsigned val;
    string       num_txt;
    pick = $urandom_range(0, 99);
    ltr = (pick < 85) ? CMD_LETTERS[$urandom_range(0, 4)] : 8'($urandom_range(1, 255));
    if (pick < 85 && $urandom_range(0, 3) == 0) ltr = ltr + CASE_DIFF;
    pick = $urandom_range(0, 99);
    if (pick < 65) val = $urandom_range(0, 4);
    else if (pick < 78) val = $urandom_range(5, 40);
    else if (pick < 86) val = $urandom_range(4190, 4200);
    else if (pick < 93) val = $urandom_range(32760, 32770);
    else val = $urandom_range(65530, 99999);
    num_txt = $sformatf("%0d", val);
    if ($urandom_range(0, 29) == 0) num_txt = "";
    else if ($urandom_range(0, 19) == 0) num_txt = {num_txt, "9876543210123456"};
    frame_byte(CH_COLON);
    frame_byte(ltr);
    repeat ($urandom_range(0, 2))
      frame_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 3)));
    pick = $urandom_range(0, 9);
    if (pick == 0) frame_byte(CH_MINUS);
    else if (pick == 1) frame_byte(CH_PLUS);
    for (int i = 0; i < num_txt.len(); i++) frame_byte(num_txt[i]);
    if ($urandom_range(0, 7) == 0) frame_byte(8'($urandom_range(1, 255)));
    // broken endings: a colon restart, or no CR at all
    pick = $urandom_range(0, 24);
    if (pick == 0) frame_byte(CH_COLON);
    else if (pick != 1) frame_byte(CH_CR);
  endfunction

  task automatic check_level(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0b, actual %0b", $time, name, want, got);
      error_count++;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 8'd1;
    case (ready_cycle[7:6])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ch.ready <= (ready_cycle[1:0] == 2'd0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    levels_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = advance_model(in_ch.operation, in_ch.data_byte);
        if (stim_q[taken_items].known) want = stim_q[taken_items].want;
        expected_levels.push_back(want);
        taken_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t unexpected result item, none outstanding", $time);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          check_level("step_out", want.step, out_ch.step_out);
          check_level("direction_out", want.dir, out_ch.direction_out);
          check_level("gripper_out", want.grip, out_ch.gripper_out);
          check_level("done_toggle", want.done, out_ch.done_toggle);
          check_level("busy_res", want.busy, out_ch.busy_res);
          check_level("time_error", want.terr, out_ch.time_error);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int burst_left;
    int wait_cycles;
    int pick;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_BYTE;
    in_ch.data_byte = 8'd0;
    reset_model();

    foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
    planned_items = 0;
    while (planned_items < 500) begin
      add_frame();
      pick = $urandom_range(0, 9);
      if (pick < 4) repeat ($urandom_range(0, 3)) push_tick();
      else if (pick < 7) repeat ($urandom_range(4, 40)) push_tick();
      // stray bytes between frames
      if ($urandom_range(0, 11) == 0)
        push_stim(OP_BYTE, $urandom_range(0, 1) ? CH_CR : 8'($urandom_range(0, 57)), 1'b0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      in_ch.valid <= 1'b1;
      in_ch.operation <= stim_q[i].op;
      in_ch.data_byte <= stim_q[i].data;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      burst_left--;
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_levels.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    if (expected_levels.size() != 0) begin
      $display("%0t %0d result items never arrived", $time, expected_levels.size());
      error_count++;
    end
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/scsp_pkg.sv
rtl/scsp_if.sv
rtl/scsp_parser.sv
rtl/serial_command_stepper_pulser.sv
bench/tb_top.sv
